// File: src/scf_pkg.sv
package scf_pkg;

  localparam int POS_W       = 32;
  localparam int MASS_W      = 32;
  localparam int REST_W      = 31;
  localparam int STIFF_W     = 17;
  localparam int DIFF_W      = 33;
  localparam int SQ_W        = 66;
  localparam int LEN_W       = 33;
  localparam int SQRT_STAGES = 33;
  localparam int REM_W       = 36;
  localparam int Q_W         = 17;
  localparam int DVD_W       = 49;
  localparam int DREM_W      = 33;
  localparam int LANES       = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_W       = 31;

  localparam logic [Q_W-1:0] ONE_Q16  = 17'd65536;
  localparam logic [Q_W-1:0] HALF_Q16 = 17'd32768;

  localparam logic [CFG_IDX_W-1:0] REG_REST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STIFF = 2'd1;

  localparam logic [REST_W-1:0]  REST_RESET  = 31'd3276800;
  localparam logic [STIFF_W-1:0] STIFF_RESET = 17'd13107;

  typedef struct packed {
    logic [DIFF_W-1:0] adx;
    logic [DIFF_W-1:0] ady;
    logic              sx;
    logic              sy;
    logic [MASS_W-1:0] ma;
    logic [DIFF_W-1:0] msum;
    logic              afix;
    logic              bfix;
  } sq_side_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             sx;
    logic             sy;
    logic             lz;
    logic             mz;
    logic             afix;
    logic             bfix;
  } dv_side_t;

  typedef struct packed {
    logic [REST_W-1:0]  rest;
    logic [STIFF_W-1:0] stiff;
  } cfg_t;

  function automatic logic signed [POS_W-1:0] sat32(input logic signed [38:0] v);
    logic signed [POS_W-1:0] r;
    if (v[38:31] == 8'h00 || v[38:31] == 8'hff) begin
      r = v[31:0];
    end else if (v[38]) begin
      r = 32'sh80000000;
    end else begin
      r = 32'sh7fffffff;
    end
    return r;
  endfunction

endpackage

// File: src/scf_if.sv
interface scf_in_if;
  logic                    valid;
  logic                    ready;
  logic signed [31:0]      a_pos_x;
  logic signed [31:0]      a_pos_y;
  logic signed [31:0]      b_pos_x;
  logic signed [31:0]      b_pos_y;
  logic [31:0]             a_mass;
  logic [31:0]             b_mass;
  logic                    a_fixed;
  logic                    b_fixed;
  modport source (output valid, a_pos_x, a_pos_y, b_pos_x, b_pos_y, a_mass, b_mass,
                  a_fixed, b_fixed, input ready);
  modport sink (input valid, a_pos_x, a_pos_y, b_pos_x, b_pos_y, a_mass, b_mass,
                a_fixed, b_fixed, output ready);
endinterface

interface scf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] a_force_x;
  logic signed [31:0] a_force_y;
  logic signed [31:0] b_force_x;
  logic signed [31:0] b_force_y;
  modport source (output valid, a_force_x, a_force_y, b_force_x, b_force_y, input ready);
  modport sink (input valid, a_force_x, a_force_y, b_force_x, b_force_y, output ready);
endinterface

// File: src/scf_front.sv
module scf_front (
  input  logic                          clk,
  input  logic                          rst_n,
  scf_in_if.sink                        in_ch,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [scf_pkg::SQ_W-1:0]      out_sq,
  output scf_pkg::sq_side_t             out_side
);

  localparam int NS = 4;

  logic [NS-1:0] v_r;
  logic [NS:0]   en;

  logic signed [scf_pkg::DIFF_W-1:0] dx_r, dy_r;
  logic [scf_pkg::MASS_W-1:0]        ma_r, mb_r;
  logic                              af_r, bf_r;
  scf_pkg::sq_side_t                 side2_r, side3_r, side4_r;
  logic [scf_pkg::SQ_W-1:0]          sqx_r, sqy_r, sum_r;
  scf_pkg::sq_side_t                 side2_nxt;

  assign en[NS] = out_ready;
  for (genvar i = 0; i < NS; i++) begin : g_en
    assign en[i] = !v_r[i] || en[i+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_ch.valid;
      for (int i = 1; i < NS; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dx_r <= $signed({in_ch.b_pos_x[31], in_ch.b_pos_x})
            - $signed({in_ch.a_pos_x[31], in_ch.a_pos_x});
      dy_r <= $signed({in_ch.b_pos_y[31], in_ch.b_pos_y})
            - $signed({in_ch.a_pos_y[31], in_ch.a_pos_y});
      ma_r <= in_ch.a_mass;
      mb_r <= in_ch.b_mass;
      af_r <= in_ch.a_fixed;
      bf_r <= in_ch.b_fixed;
    end
  end

  always_comb begin
    side2_nxt.sx   = dx_r[scf_pkg::DIFF_W-1];
    side2_nxt.sy   = dy_r[scf_pkg::DIFF_W-1];
    side2_nxt.adx  = dx_r[scf_pkg::DIFF_W-1] ? 33'(-dx_r) : 33'(dx_r);
    side2_nxt.ady  = dy_r[scf_pkg::DIFF_W-1] ? 33'(-dy_r) : 33'(dy_r);
    side2_nxt.ma   = ma_r;
    side2_nxt.msum = {1'b0, ma_r} + {1'b0, mb_r};
    side2_nxt.afix = af_r;
    side2_nxt.bfix = bf_r;
  end

  always_ff @(posedge clk) begin
    if (en[1]) side2_r <= side2_nxt;
    if (en[2]) begin
      sqx_r   <= {33'b0, side2_r.adx} * {33'b0, side2_r.adx};
      sqy_r   <= {33'b0, side2_r.ady} * {33'b0, side2_r.ady};
      side3_r <= side2_r;
    end
    if (en[3]) begin
      sum_r   <= sqx_r + sqy_r;
      side4_r <= side3_r;
    end
  end

  assign in_ch.ready = en[0];
  assign out_valid   = v_r[NS-1];
  assign out_sq      = sum_r;
  assign out_side    = side4_r;

endmodule

// File: src/scf_isqrt.sv
module scf_isqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [scf_pkg::SQ_W-1:0]  in_sq,
  input  scf_pkg::sq_side_t         in_side,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [scf_pkg::LEN_W-1:0] out_len,
  output scf_pkg::sq_side_t         out_side
);

  localparam int NS = scf_pkg::SQRT_STAGES;

  logic [NS-1:0] v_r;
  logic [NS:0]   en;

  logic [scf_pkg::REM_W-1:0] rem_r  [NS];
  logic [scf_pkg::LEN_W-1:0] res_r  [NS];
  logic [scf_pkg::SQ_W-1:0]  val_r  [NS];
  scf_pkg::sq_side_t         side_r [NS];

  assign en[NS] = out_ready;
  for (genvar i = 0; i < NS; i++) begin : g_en
    assign en[i] = !v_r[i] || en[i+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int i = 1; i < NS; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam int P = NS - 1 - k;
    logic [scf_pkg::REM_W-1:0] rem_p, rem_sh, trial, rem_nxt;
    logic [scf_pkg::LEN_W-1:0] res_p, res_nxt;
    logic [scf_pkg::SQ_W-1:0]  val_p;
    scf_pkg::sq_side_t         side_p;
    logic                      ge;

    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign res_p  = '0;
      assign val_p  = in_sq;
      assign side_p = in_side;
    end else begin : g_next
      assign rem_p  = rem_r[k-1];
      assign res_p  = res_r[k-1];
      assign val_p  = val_r[k-1];
      assign side_p = side_r[k-1];
    end

    assign rem_sh  = {rem_p[scf_pkg::REM_W-3:0], val_p[2*P+1 -: 2]};
    assign trial   = {1'b0, res_p, 2'b01};
    assign ge      = rem_sh >= trial;
    assign rem_nxt = ge ? rem_sh - trial : rem_sh;
    assign res_nxt = {res_p[scf_pkg::LEN_W-2:0], ge};

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_r[k]  <= rem_nxt;
        res_r[k]  <= res_nxt;
        val_r[k]  <= val_p;
        side_r[k] <= side_p;
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NS-1];
  assign out_len   = res_r[NS-1];
  assign out_side  = side_r[NS-1];

endmodule

// File: src/scf_div.sv
module scf_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [scf_pkg::DVD_W-1:0]  in_dvd [scf_pkg::LANES],
  input  logic [scf_pkg::DREM_W-1:0] in_dsr [scf_pkg::LANES],
  input  scf_pkg::dv_side_t          in_side,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [scf_pkg::Q_W-1:0]    out_q [scf_pkg::LANES],
  output scf_pkg::dv_side_t          out_side
);

  localparam int NS = scf_pkg::Q_W;
  localparam int NL = scf_pkg::LANES;

  logic [NS-1:0] v_r;
  logic [NS:0]   en;

  logic [scf_pkg::DREM_W-1:0] rem_r [NS][NL];
  logic [scf_pkg::Q_W-1:0]    q_r   [NS][NL];
  logic [scf_pkg::DVD_W-1:0]  dvd_r [NS][NL];
  logic [scf_pkg::DREM_W-1:0] dsr_r [NS][NL];
  scf_pkg::dv_side_t          side_r [NS];

  assign en[NS] = out_ready;
  for (genvar i = 0; i < NS; i++) begin : g_en
    assign en[i] = !v_r[i] || en[i+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int i = 1; i < NS; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam int J = NS - 1 - k;
    scf_pkg::dv_side_t side_p;

    if (k == 0) begin : g_sf
      assign side_p = in_side;
    end else begin : g_sn
      assign side_p = side_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (en[k]) side_r[k] <= side_p;
    end

    for (genvar l = 0; l < NL; l++) begin : g_lane
      logic [scf_pkg::DREM_W-1:0] rem_p, dsr_p, rem_nxt;
      logic [scf_pkg::Q_W-1:0]    q_p, q_nxt;
      logic [scf_pkg::DVD_W-1:0]  dvd_p;
      logic [scf_pkg::DREM_W:0]   t, diff;
      logic                       ge;

      if (k == 0) begin : g_lf
        assign rem_p = {1'b0, in_dvd[l][scf_pkg::DVD_W-1:scf_pkg::Q_W]};
        assign q_p   = '0;
        assign dvd_p = in_dvd[l];
        assign dsr_p = in_dsr[l];
      end else begin : g_ln
        assign rem_p = rem_r[k-1][l];
        assign q_p   = q_r[k-1][l];
        assign dvd_p = dvd_r[k-1][l];
        assign dsr_p = dsr_r[k-1][l];
      end

      assign t       = {rem_p, dvd_p[J]};
      assign ge      = t >= {1'b0, dsr_p};
      assign diff    = t - {1'b0, dsr_p};
      assign rem_nxt = ge ? diff[scf_pkg::DREM_W-1:0] : t[scf_pkg::DREM_W-1:0];
      assign q_nxt   = {q_p[scf_pkg::Q_W-2:0], ge};

      always_ff @(posedge clk) begin
        if (en[k]) begin
          rem_r[k][l] <= rem_nxt;
          q_r[k][l]   <= q_nxt;
          dvd_r[k][l] <= dvd_p;
          dsr_r[k][l] <= dsr_p;
        end
      end
    end
  end

  for (genvar l = 0; l < NL; l++) begin : g_out
    assign out_q[l] = q_r[NS-1][l];
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NS-1];
  assign out_side  = side_r[NS-1];

endmodule

// File: src/scf_back.sv
module scf_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  scf_pkg::cfg_t           cfg,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [scf_pkg::Q_W-1:0] in_q [scf_pkg::LANES],
  input  scf_pkg::dv_side_t       in_side,
  scf_out_if.source               out_ch
);

  localparam int NS = 5;

  logic [NS-1:0] v_r;
  logic [NS:0]   en;

  logic signed [17:0] ux1_r, uy1_r, ux2_r, uy2_r, ux3_r, uy3_r;
  logic [16:0]        wa1_r, wb1_r, wa2_r, wb2_r;
  logic signed [33:0] ext1_r;
  logic signed [35:0] fac2_r, sa3_r, sb3_r;
  logic signed [53:0] pax4_r, pay4_r, pbx4_r, pby4_r;
  logic signed [31:0] fax5_r, fay5_r, fbx5_r, fby5_r;

  logic signed [17:0] ux1_nxt, uy1_nxt;
  logic [16:0]        mf, wa1_nxt, wb1_nxt;
  logic signed [51:0] fprod;
  logic signed [53:0] pa, pb;

  assign en[NS] = out_ch.ready;
  for (genvar i = 0; i < NS; i++) begin : g_en
    assign en[i] = !v_r[i] || en[i+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int i = 1; i < NS; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  always_comb begin
    if (in_side.lz) begin
      ux1_nxt = $signed({1'b0, scf_pkg::ONE_Q16});
      uy1_nxt = '0;
    end else begin
      ux1_nxt = in_side.sx ? -$signed({1'b0, in_q[0]}) : $signed({1'b0, in_q[0]});
      uy1_nxt = in_side.sy ? -$signed({1'b0, in_q[1]}) : $signed({1'b0, in_q[1]});
    end
    mf      = in_side.mz ? scf_pkg::HALF_Q16 : in_q[2];
    wa1_nxt = in_side.bfix ? scf_pkg::ONE_Q16 : scf_pkg::ONE_Q16 - mf;
    wb1_nxt = in_side.afix ? scf_pkg::ONE_Q16 : mf;
  end

  assign fprod = $signed({1'b0, cfg.stiff}) * ext1_r;
  assign pa    = fac2_r * $signed({1'b0, wa2_r});
  assign pb    = fac2_r * $signed({1'b0, wb2_r});

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ux1_r  <= ux1_nxt;
      uy1_r  <= uy1_nxt;
      wa1_r  <= wa1_nxt;
      wb1_r  <= wb1_nxt;
      ext1_r <= $signed({1'b0, in_side.len}) - $signed({3'b0, cfg.rest});
    end
    if (en[1]) begin
      fac2_r <= fprod[51:16];
      ux2_r  <= ux1_r;
      uy2_r  <= uy1_r;
      wa2_r  <= wa1_r;
      wb2_r  <= wb1_r;
    end
    if (en[2]) begin
      sa3_r <= pa[51:16];
      sb3_r <= pb[51:16];
      ux3_r <= ux2_r;
      uy3_r <= uy2_r;
    end
    if (en[3]) begin
      pax4_r <= ux3_r * sa3_r;
      pay4_r <= uy3_r * sa3_r;
      pbx4_r <= ux3_r * sb3_r;
      pby4_r <= uy3_r * sb3_r;
    end
    if (en[4]) begin
      fax5_r <= scf_pkg::sat32({pax4_r[53], pax4_r[53:16]});
      fay5_r <= scf_pkg::sat32({pay4_r[53], pay4_r[53:16]});
      fbx5_r <= scf_pkg::sat32(-$signed({pbx4_r[53], pbx4_r[53:16]}));
      fby5_r <= scf_pkg::sat32(-$signed({pby4_r[53], pby4_r[53:16]}));
    end
  end

  assign in_ready         = en[0];
  assign out_ch.valid     = v_r[NS-1];
  assign out_ch.a_force_x = fax5_r;
  assign out_ch.a_force_y = fay5_r;
  assign out_ch.b_force_x = fbx5_r;
  assign out_ch.b_force_y = fby5_r;

endmodule

// File: src/spring_constraint_force.sv
// Hooke spring force between two 2D endpoints in Q16.16, one item per clock
// unless stalled: a front end forms the difference vector and squared length,
// the exact square root yields one result bit per stage over 33 stages, the
// unit vector and mass split share a 17-stage divider with one quotient bit per
// stage, and a back end applies stiffness, mass weights and saturation. A full
// stage waits while the one ahead is blocked, so empty stages fill as the
// output waits. The user must write rest_length and stiffness through cfg_*
// only while no item is in flight; the block does not enforce this.
module spring_constraint_force (
  input  logic                             clk,
  input  logic                             rst_n,
  scf_in_if.sink                           in_ch,
  scf_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [scf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [scf_pkg::CFG_W-1:0]        cfg_wdata
);

  scf_pkg::cfg_t cfg_r, cfg_nxt;

  logic                       f_valid, f_ready;
  logic [scf_pkg::SQ_W-1:0]   f_sq;
  scf_pkg::sq_side_t          f_side;
  logic                       s_valid, s_ready;
  logic [scf_pkg::LEN_W-1:0]  s_len;
  scf_pkg::sq_side_t          s_side;
  logic [scf_pkg::DVD_W-1:0]  d_dvd [scf_pkg::LANES];
  logic [scf_pkg::DREM_W-1:0] d_dsr [scf_pkg::LANES];
  scf_pkg::dv_side_t          d_side;
  logic                       q_valid, q_ready;
  logic [scf_pkg::Q_W-1:0]    q_q [scf_pkg::LANES];
  scf_pkg::dv_side_t          q_side;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        scf_pkg::REG_REST:  cfg_nxt.rest  = cfg_wdata;
        scf_pkg::REG_STIFF: cfg_nxt.stiff = cfg_wdata[scf_pkg::STIFF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rest  <= scf_pkg::REST_RESET;
      cfg_r.stiff <= scf_pkg::STIFF_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  scf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_sq    (f_sq),
    .out_side  (f_side)
  );

  scf_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_sq     (f_sq),
    .in_side   (f_side),
    .out_valid (s_valid),
    .out_ready (s_ready),
    .out_len   (s_len),
    .out_side  (s_side)
  );

  always_comb begin
    d_dvd[0]    = {s_side.adx, 16'b0};
    d_dvd[1]    = {s_side.ady, 16'b0};
    d_dvd[2]    = {1'b0, s_side.ma, 16'b0};
    d_dsr[0]    = s_len;
    d_dsr[1]    = s_len;
    d_dsr[2]    = s_side.msum;
    d_side.len  = s_len;
    d_side.sx   = s_side.sx;
    d_side.sy   = s_side.sy;
    d_side.lz   = s_len == '0;
    d_side.mz   = s_side.msum == '0;
    d_side.afix = s_side.afix;
    d_side.bfix = s_side.bfix;
  end

  scf_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s_valid),
    .in_ready  (s_ready),
    .in_dvd    (d_dvd),
    .in_dsr    (d_dsr),
    .in_side   (d_side),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_q     (q_q),
    .out_side  (q_side)
  );

  scf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (q_valid),
    .in_ready (q_ready),
    .in_q     (q_q),
    .in_side  (q_side),
    .out_ch   (out_ch)
  );

  a_stall_from_output: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_ch.valid && !out_ch.ready))
    else $error("input stalled while output is free");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

  a_inner_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s_valid && !s_ready) |-> (q_valid && !q_ready))
    else $error("divider stalled while back end is free");

endmodule

// File: tb/sv/spring_constraint_force_test.sv
module spring_constraint_force_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 80;

  localparam logic [scf_pkg::CFG_IDX_W-1:0] REG_SPARE2 = 2'd2;
  localparam logic [scf_pkg::CFG_IDX_W-1:0] REG_SPARE3 = 2'd3;

  typedef struct packed {
    logic signed [31:0] fax;
    logic signed [31:0] fay;
    logic signed [31:0] fbx;
    logic signed [31:0] fby;
  } force_t;

  typedef struct packed {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic [31:0]        ma;
    logic [31:0]        mb;
    logic               af;
    logic               bf;
    logic               typed;
    force_t             want;
  } spring_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [scf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [scf_pkg::CFG_W-1:0] cfg_wdata = '0;

  scf_in_if in_ch();
  scf_out_if out_ch();

  spring_constraint_force dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  logic [scf_pkg::REST_W-1:0] rest_cur = scf_pkg::REST_RESET;
  logic [scf_pkg::STIFF_W-1:0] stiff_cur = scf_pkg::STIFF_RESET;

  force_t force_q[$];
  spring_t send_q[$];
  int fails = 0;
  int n_items = 0;
  int n_forces = 0;
  int n_cfg = 0;
  int cycles = 0;
  bit hold_go = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [32:0] root66(input logic [65:0] v);
    logic [32:0] r;
    logic [37:0] rem;
    logic [37:0] trial;
    r = '0;
    rem = '0;
    for (int i = 32; i >= 0; i--) begin
      rem = {rem[35:0], v[2*i+1 -: 2]};
      trial = {3'b0, r, 2'b01};
      if (rem >= trial) begin
        rem = rem - trial;
        r = {r[31:0], 1'b1};
      end else begin
        r = {r[31:0], 1'b0};
      end
    end
    return r;
  endfunction

  function automatic logic signed [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic force_t spring_force(input spring_t s);
    longint dx, dy, len, ext, fac, ux, uy, mf, wa, wb, sa, sb;
    logic [65:0] adx, ady;
    logic [32:0] msum;
    force_t f;
    dx = longint'(s.bx) - longint'(s.ax);
    dy = longint'(s.by) - longint'(s.ay);
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    len = longint'(root66(adx * adx + ady * ady));
    ext = len - longint'(rest_cur);
    fac = (longint'(stiff_cur) * ext) >>> 16;
    if (len != 0) begin
      ux = (dx * 65536) / len;
      uy = (dy * 65536) / len;
    end else begin
      ux = 65536;
      uy = 0;
    end
    msum = {1'b0, s.ma} + {1'b0, s.mb};
    mf = (msum != 0) ? (longint'(s.ma) * 65536) / longint'(msum) : 32768;
    wa = s.bf ? 65536 : 65536 - mf;
    wb = s.af ? 65536 : mf;
    sa = (fac * wa) >>> 16;
    sb = (fac * wb) >>> 16;
    f.fax = clip32((ux * sa) >>> 16);
    f.fay = clip32((uy * sa) >>> 16);
    f.fbx = clip32(-((ux * sb) >>> 16));
    f.fby = clip32(-((uy * sb) >>> 16));
    return f;
  endfunction

  function automatic spring_t row(input logic signed [31:0] ax, ay, bx, by,
                                  input logic [31:0] ma, mb, input logic af, bf,
                                  input logic typed = 1'b0, input force_t want = '0);
    spring_t s;
    s = '{ax, ay, bx, by, ma, mb, af, bf, typed, want};
    return s;
  endfunction

  function automatic logic signed [31:0] near(input logic signed [31:0] c, input int span);
    return c + $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic spring_t rand_spring();
    spring_t s;
    int kind;
    kind = $urandom_range(0, 9);
    s = '0;
    if (kind < 2) begin
      s.ax = $urandom; s.ay = $urandom; s.bx = $urandom; s.by = $urandom;
      s.ma = $urandom; s.mb = $urandom;
    end else begin
      s.ax = near(0, 1 << 23);
      s.ay = near(0, 1 << 23);
      s.bx = (kind == 2) ? s.ax : near(s.ax, 1 << 22);
      s.by = (kind == 2) ? s.ay : near(s.ay, 1 << 22);
      s.ma = $urandom_range(1, 1 << 20);
      s.mb = $urandom_range(1, 1 << 20);
      if (kind == 3) s.ma = ($urandom_range(0, 1) != 0) ? 32'hffffffff : 32'h0;
      if (kind == 4) s.mb = ($urandom_range(0, 1) != 0) ? 32'hffffffff : 32'h0;
    end
    s.af = ($urandom_range(0, 3) == 0);
    s.bf = ($urandom_range(0, 3) == 0);
    return s;
  endfunction

  task automatic write_reg(input logic [scf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [scf_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    if (idx == scf_pkg::REG_REST) rest_cur = val[scf_pkg::REST_W-1:0];
    else if (idx == scf_pkg::REG_STIFF) stiff_cur = val[scf_pkg::STIFF_W-1:0];
    n_cfg++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_items();
    int burst;
    spring_t s;
    burst = 0;
    while (send_q.size() != 0) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        @(negedge clk);
        in_ch.valid = 1'b0;
        repeat ($urandom_range(0, 1) * $urandom_range(1, 6)) @(negedge clk);
      end
      s = send_q.pop_front();
      if (burst != 0 && in_ch.valid == 1'b0) begin
      end else begin
        @(negedge clk);
      end
      in_ch.valid = 1'b1;
      in_ch.a_pos_x = s.ax; in_ch.a_pos_y = s.ay;
      in_ch.b_pos_x = s.bx; in_ch.b_pos_y = s.by;
      in_ch.a_mass = s.ma; in_ch.b_mass = s.mb;
      in_ch.a_fixed = s.af; in_ch.b_fixed = s.bf;
      do @(posedge clk); while (!in_ch.ready);
      force_q.push_back(s.typed ? s.want : spring_force(s));
      n_items++;
      burst--;
    end
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic drain();
    while (force_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(input int count);
    repeat (count) send_q.push_back(rand_spring());
    send_items();
    drain();
  endtask

  always @(negedge clk) begin : receiver
    int hold;
    if (hold_go) begin
      hold = 400;
      hold_go = 1'b0;
    end
    if (hold > 0) begin
      out_ch.ready = 1'b0;
      hold--;
    end else if ((cycles / 150) % 3 == 0) begin
      out_ch.ready = 1'b1;
    end else begin
      out_ch.ready = ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    force_t e;
    if (out_ch.valid && out_ch.ready) begin
      n_forces++;
      if (force_q.size() == 0) begin
        $error("unexpected result item");
        fails++;
      end else begin
        e = force_q.pop_front();
        if (out_ch.a_force_x !== e.fax) begin
          $error("a_force_x expected %0d actual %0d", e.fax, out_ch.a_force_x); fails++;
        end
        if (out_ch.a_force_y !== e.fay) begin
          $error("a_force_y expected %0d actual %0d", e.fay, out_ch.a_force_y); fails++;
        end
        if (out_ch.b_force_x !== e.fbx) begin
          $error("b_force_x expected %0d actual %0d", e.fbx, out_ch.b_force_x); fails++;
        end
        if (out_ch.b_force_y !== e.fby) begin
          $error("b_force_y expected %0d actual %0d", e.fby, out_ch.b_force_y); fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  localparam logic signed [31:0] PMAX = 32'sh7fffffff;
  localparam logic signed [31:0] PMIN = 32'sh80000000;
  localparam logic [31:0] MMAX = 32'hffffffff;

  initial begin
    spring_t dir_tab[];
    in_ch.valid = 1'b0;
    in_ch.a_pos_x = '0; in_ch.a_pos_y = '0; in_ch.b_pos_x = '0; in_ch.b_pos_y = '0;
    in_ch.a_mass = '0; in_ch.b_mass = '0; in_ch.a_fixed = 1'b0; in_ch.b_fixed = 1'b0;
    out_ch.ready = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    dir_tab = '{
      row(0, 0, 0, 0, 32'h10000, 32'h10000, 0, 0, 1,
          '{-32'sd327675, 32'sd0, 32'sd327675, 32'sd0}),
      row(0, 0, 32'sh00640000, 0, 32'h10000, 32'h10000, 0, 0),
      row(0, 0, 32'sh000a0000, 32'sh000a0000, 32'h10000, 32'h30000, 0, 0),
      row(PMIN, PMIN, PMAX, PMAX, MMAX, MMAX, 0, 0),
      row(PMAX, PMAX, PMIN, PMIN, 32'h1, MMAX, 0, 0),
      row(PMIN, 0, PMAX, 0, MMAX, 32'h1, 0, 0),
      row(0, PMAX, 0, PMIN, 32'h10000, 32'h10000, 1, 0),
      row(32'sh00010000, 0, 0, 32'sh00c80000, 32'h10000, 32'h10000, 0, 1),
      row(0, 0, -32'sh00c80000, -32'sh00030000, 32'h20000, 32'h10000, 1, 1),
      row(5, 7, 5, 7, 32'h0, 32'h0, 0, 0),
      row(0, 0, 32'sh00320000, 0, 32'h0, 32'h0, 0, 0),
      row(0, 0, 1, -1, 32'h1, 32'h1, 0, 0)
    };
    foreach (dir_tab[i]) send_q.push_back(dir_tab[i]);
    send_items();
    drain();
    random_phase(200);

    write_reg(scf_pkg::REG_REST, 31'd1);
    write_reg(scf_pkg::REG_STIFF, 31'd0);
    random_phase(150);

    write_reg(scf_pkg::REG_REST, 31'h7fffffff);
    write_reg(scf_pkg::REG_STIFF, 31'd65536);
    hold_go = 1'b1;
    random_phase(200);

    write_reg(scf_pkg::REG_REST, 31'd0);
    write_reg(scf_pkg::REG_STIFF, 31'h1ffff);
    write_reg(REG_SPARE2, 31'h12345);
    write_reg(REG_SPARE3, 31'h7fffffff);
    random_phase(200);

    write_reg(scf_pkg::REG_REST, 31'($urandom));
    write_reg(scf_pkg::REG_STIFF, 31'($urandom_range(0, 65536)));
    random_phase(250);

    $display("covered %0d items, %0d results, %0d register writes, %0d cycles",
             n_items, n_forces, n_cfg, cycles);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", fails);
      $display("status: fail");
    end
    $finish;
  end

endmodule
